// ----- design/lif_neuron_array_step_top_macros.svh -----
// assertion macros shared by the lif neuron array checker
`ifndef LIF_NEURON_ARRAY_STEP_TOP_MACROS_SVH
`define LIF_NEURON_ARRAY_STEP_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define LIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lif check failed");

// next-cycle implication, off during reset
`define LIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lif check failed");

// next-cycle implication that also holds through reset
`define LIF_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lif check failed");

`endif

// ----- design/lif_pkg.sv -----
// shared constants and helpers for the lif neuron array
package lif_pkg;

  localparam int NEURONS_DEF       = 256;
  localparam int MEMBRANE_BITS_DEF = 32;

  localparam int NEURON_W    = 8;
  localparam int CURRENT_W   = 32;
  localparam int LEAK_W      = 15;
  localparam int THRESH_W    = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int ROUND_SHIFT = 15;

  localparam logic [LEAK_W-1:0]   LEAK_MAX     = 15'd32765;
  localparam logic [LEAK_W-1:0]   LEAK_RESET   = 15'd29491;
  localparam logic [THRESH_W-1:0] THRESH_MIN   = 31'd7;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEAK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

  // neuron field modulo the array size, restoring compare-subtract over 8 bits
  function automatic logic [NEURON_W-1:0] wrap_index(input logic [NEURON_W-1:0] nfield,
                                                     input int neurons);
    logic [19:0] r;
    logic [19:0] step;
    r = 20'(nfield);
    for (int k = NEURON_W - 1; k >= 0; k--) begin
      step = 20'(neurons) << k;
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[NEURON_W-1:0];
  endfunction

endpackage

// ----- design/lif_ram.sv -----
// generic single-write, single-read ram with registered read data
module lif_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/lif_neuron_array_step_top.sv -----
// leaky integrate-and-fire neuron array, one neuron update per word
// path: ram read into stage 1, leak multiply into stage 2, then sum and compare into the output register
// throughput: one word per cycle unless the output stalls; a word for a neuron still in either
//   of the two pipeline stages waits, set by the membrane ram read-modify-write loop
// reset: synchronous rst_n clears the pipeline and loads the register defaults;
//   the membrane ram is not cleared, so each neuron's first word carries first_step
module lif_neuron_array_step_top #(
  parameter int NEURONS       = lif_pkg::NEURONS_DEF,
  parameter int MEMBRANE_BITS = lif_pkg::MEMBRANE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: neuron [7:0], current [39:8]; in_tuser: first_step
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lif_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  // out_tdata: neuron_out [7:0], spike [8], membrane [40:9], zero [47:41]; out_tuser: saturated
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lif_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lif_pkg::THRESH_W-1:0]       cfg_data
);

  localparam int IDX_W       = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int MB          = MEMBRANE_BITS;
  localparam int ENTRY_W     = MB + 1;
  localparam int PROD_W      = MB + 16;
  localparam int LEAK_TERM_W = PROD_W - lif_pkg::ROUND_SHIFT;
  localparam int ADD_W       = lif_pkg::CURRENT_W + 1;
  localparam int SUM_W       = ((LEAK_TERM_W > ADD_W) ? LEAK_TERM_W : ADD_W) + 1;
  localparam int ROUND_HALF  = 1 << (lif_pkg::ROUND_SHIFT - 1);

  localparam logic signed [SUM_W-1:0] VMAX = {{(SUM_W-MB+1){1'b0}}, {(MB-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN = ~VMAX;

  // configuration registers
  logic [lif_pkg::LEAK_W-1:0]   leak_r, leak_nxt;
  logic [lif_pkg::THRESH_W-1:0] thresh_r, thresh_nxt;

  // pipeline registers
  logic                                s1_valid_r, s2_valid_r, out_valid_r;
  logic [IDX_W-1:0]                    s1_idx_r, s2_idx_r;
  logic [lif_pkg::NEURON_W-1:0]        s1_neuron_r, s2_neuron_r, out_neuron_r;
  logic signed [lif_pkg::CURRENT_W-1:0] s1_current_r;
  logic                                s1_first_r;
  logic signed [PROD_W-1:0]            s2_prod_r, prod_nxt;
  logic signed [ADD_W-1:0]             s2_addend_r, addend_nxt;
  logic                                out_spike_r, out_sat_r;
  logic [lif_pkg::CURRENT_W-1:0]       out_membrane_r;

  // input decode and flow control
  logic [lif_pkg::NEURON_W-1:0]         in_neuron;
  logic signed [lif_pkg::CURRENT_W-1:0] in_current;
  logic [IDX_W-1:0]                     in_idx;
  logic                                 hit, in_accept;
  logic                                 out_free, s2_free, s1_free, s2_move, s1_move;

  // ram
  logic [ENTRY_W-1:0] rd_data, wr_data;

  // stage 1 and 2 datapath
  logic signed [MB-1:0]     v_prev;
  logic                     s_prev;
  logic signed [15:0]       alpha_s;
  logic signed [ADD_W-1:0]  thr_term;
  logic signed [PROD_W-1:0] rnd;
  logic signed [LEAK_TERM_W-1:0] leak_term;
  logic signed [SUM_W-1:0]  sum, v_sat, thr_ext;
  logic                     sat_hi, sat_lo, spike;

  // register writes, clamped into range
  always_comb begin
    leak_nxt   = (cfg_data[lif_pkg::LEAK_W-1:0] > lif_pkg::LEAK_MAX) ?
                 lif_pkg::LEAK_MAX : cfg_data[lif_pkg::LEAK_W-1:0];
    thresh_nxt = (cfg_data < lif_pkg::THRESH_MIN) ? lif_pkg::THRESH_MIN : cfg_data;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r   <= lif_pkg::LEAK_RESET;
      thresh_r <= lif_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lif_pkg::REG_LEAK:   leak_r   <= leak_nxt;
        lif_pkg::REG_THRESH: thresh_r <= thresh_nxt;
        default: ;
      endcase
    end
  end

  // input fields and wrapped ram index
  assign in_neuron  = in_tdata[lif_pkg::NEURON_W-1:0];
  assign in_current = $signed(in_tdata[lif_pkg::NEURON_W +: lif_pkg::CURRENT_W]);
  assign in_idx     = IDX_W'(lif_pkg::wrap_index(in_neuron, NEURONS));

  // stall on a neuron whose update has not reached the ram yet
  assign hit = (s1_valid_r && (s1_idx_r == in_idx)) || (s2_valid_r && (s2_idx_r == in_idx));

  assign out_free  = !out_valid_r || out_tready;
  assign s2_move   = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_move   = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = s1_free && !hit;
  assign in_accept = in_tvalid && in_tready;

  // membrane and spike store: {spike, membrane}
  lif_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NEURONS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (s2_move),
    .wr_addr (s2_idx_r),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx_r     <= in_idx;
      s1_neuron_r  <= in_neuron;
      s1_current_r <= in_current;
      s1_first_r   <= in_tuser;
    end
  end

  // stage 1: leak multiply and current minus reset term
  always_comb begin
    v_prev     = s1_first_r ? '0 : $signed(rd_data[MB-1:0]);
    s_prev     = !s1_first_r && rd_data[MB];
    alpha_s    = $signed({1'b0, leak_r});
    prod_nxt   = v_prev * alpha_s;
    thr_term   = s_prev ? $signed({2'b00, thresh_r}) : '0;
    addend_nxt = ADD_W'(s1_current_r) - thr_term;
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_idx_r    <= s1_idx_r;
      s2_neuron_r <= s1_neuron_r;
      s2_prod_r   <= prod_nxt;
      s2_addend_r <= addend_nxt;
    end
  end

  // stage 2: round, sum, saturate, compare
  always_comb begin
    rnd       = s2_prod_r + PROD_W'(ROUND_HALF);
    leak_term = $signed(rnd[PROD_W-1:lif_pkg::ROUND_SHIFT]);
    sum       = SUM_W'(leak_term) + SUM_W'(s2_addend_r);
    sat_hi    = sum > VMAX;
    sat_lo    = sum < VMIN;
    if (sat_hi) begin
      v_sat = VMAX;
    end else if (sat_lo) begin
      v_sat = VMIN;
    end else begin
      v_sat = sum;
    end
    thr_ext = $signed({{(SUM_W-lif_pkg::THRESH_W){1'b0}}, thresh_r});
    spike   = v_sat >= thr_ext;
    wr_data = {spike, v_sat[MB-1:0]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_neuron_r   <= s2_neuron_r;
      out_spike_r    <= spike;
      out_membrane_r <= v_sat[lif_pkg::CURRENT_W-1:0];
      out_sat_r      <= sat_hi || sat_lo;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_membrane_r, out_spike_r, out_neuron_r};
  assign out_tuser  = out_sat_r;

endmodule

// ----- design/lif_step_chk.sv -----
// port-level checker for the lif neuron array, bound to the top level
`include "lif_neuron_array_step_top_macros.svh"

module lif_step_chk #(
  parameter int MEMBRANE_BITS = lif_pkg::MEMBRANE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lif_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  localparam logic [63:0] VMAX64 = (64'd1 << (MEMBRANE_BITS - 1)) - 64'd1;
  localparam logic [63:0] VMIN64 = ~VMAX64;
  localparam logic [31:0] VMAX32 = VMAX64[31:0];
  localparam logic [31:0] VMIN32 = VMIN64[31:0];

  // a stalled result word stays offered and unchanged
  `LIF_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `LIF_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

  // reset empties the output stage
  `LIF_ASSERT_ALWAYS_NXT(a_reset_empty, clk, !rst_n, !out_tvalid)

  // a clipped membrane sits at one end of the range
  `LIF_ASSERT_IMP(a_sat_extreme, clk, rst_n, out_tvalid && out_tuser, (out_tdata[40:9] == VMAX32) || (out_tdata[40:9] == VMIN32))

endmodule

bind lif_neuron_array_step_top lif_step_chk #(.MEMBRANE_BITS(MEMBRANE_BITS)) u_lif_step_chk (.*);

// ----- test/tb_lif_neuron_array_step_top.sv -----
// testbench for the lif neuron array: stream driver, result monitor and membrane predictor
`timescale 1ns / 1ps

module tb_lif_neuron_array_step_top;

  localparam logic [lif_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lif_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam longint V_MAX = 64'sd2147483647;
  localparam longint V_MIN = -64'sd2147483648;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [lif_pkg::NEURON_W-1:0]         neuron;
    logic signed [lif_pkg::CURRENT_W-1:0] current;
    logic                                 first_step;
  } neuron_word_t;

  typedef struct {
    logic [lif_pkg::NEURON_W-1:0] neuron;
    logic                         spike;
    logic [31:0]                  membrane;
    logic                         saturated;
  } neuron_report_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lif_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lif_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lif_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [lif_pkg::THRESH_W-1:0]    cfg_data = '0;

  // predictor state: register copies and per-neuron membrane and spike
  logic [lif_pkg::LEAK_W-1:0]   leak_now = lif_pkg::LEAK_RESET;
  logic [lif_pkg::THRESH_W-1:0] thresh_now = lif_pkg::THRESH_RESET;
  logic signed [31:0]           membrane_mem [256];
  logic                         spike_mem [256];

  neuron_word_t   stim_q [$];
  neuron_report_t due_reports [$];
  logic [lif_pkg::NEURON_W-1:0] hot_neurons [$];
  bit             touched [256];
  int             words_planned = 0;
  int             reports_seen = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             hold_go = 1'b0;
  logic           hold_active = 1'b0;
  bit             failed = 1'b0;

  lif_neuron_array_step_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // membrane update for one accepted word, queues the expected report
  function automatic void leak_and_fire(neuron_word_t w);
    longint prev;
    longint v;
    bit sprev;
    neuron_report_t r;
    prev = w.first_step ? 64'sd0 : longint'(membrane_mem[w.neuron]);
    sprev = w.first_step ? 1'b0 : spike_mem[w.neuron];
    // leak product rounded half up from q15.31 to q15.16
    v = ((prev * longint'(leak_now) + 64'sd16384) >>> 15) + longint'(w.current);
    if (sprev) v = v - longint'(thresh_now);
    r.saturated = 1'b0;
    if (v > V_MAX) begin
      v = V_MAX;
      r.saturated = 1'b1;
    end else if (v < V_MIN) begin
      v = V_MIN;
      r.saturated = 1'b1;
    end
    r.neuron = w.neuron;
    r.spike = (v >= longint'(thresh_now));
    r.membrane = v[31:0];
    membrane_mem[w.neuron] = v[31:0];
    spike_mem[w.neuron] = r.spike;
    due_reports.push_back(r);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // word driver: holds a word until accepted, then maybe idles before the next
  always @(posedge clk) begin : drive_words
    logic nv;
    neuron_word_t on_bus;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        leak_and_fire(on_bus);
        nv = 1'b0;
      end
      if (!nv && stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        on_bus = stim_q.pop_front();
        nv = 1'b1;
        in_tdata <= {on_bus.current, on_bus.neuron};
        in_tuser <= on_bus.first_step;
      end
      in_tvalid <= nv;
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin : watch_reports
    neuron_report_t r;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (due_reports.size() == 0) begin
        $error("output word with no expected report: %0h", out_tdata);
        failed = 1'b1;
      end else begin
        r = due_reports.pop_front();
        check_field("neuron_out", r.neuron, out_tdata[7:0]);
        check_field("spike", r.spike, out_tdata[8]);
        check_field("membrane", r.membrane, out_tdata[40:9]);
        check_field("pad", 0, out_tdata[47:41]);
        check_field("saturated", r.saturated, out_tuser);
      end
    end
    out_tready <= rst_n && !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // one long receiver hold-off so the pipeline fills and stalls the input
  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // register write over the config channel, mirrored into the predictor
  task automatic write_reg(logic [lif_pkg::CFG_IDX_W-1:0] idx,
                           logic [lif_pkg::THRESH_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lif_pkg::REG_LEAK:
        leak_now = (data[lif_pkg::LEAK_W-1:0] > lif_pkg::LEAK_MAX) ?
                   lif_pkg::LEAK_MAX : data[lif_pkg::LEAK_W-1:0];
      lif_pkg::REG_THRESH:
        thresh_now = (data < lif_pkg::THRESH_MIN) ? lif_pkg::THRESH_MIN : data;
      default: ;
    endcase
  endtask

  task automatic plan(logic [lif_pkg::NEURON_W-1:0] n, logic signed [31:0] c, bit f);
    neuron_word_t w;
    w.neuron = n;
    w.current = c;
    w.first_step = f;
    stim_q.push_back(w);
    touched[n] = 1'b1;
    words_planned++;
  endtask

  // random word: half the time a neuron from a small live set; currents near the threshold half the time
  task automatic plan_random();
    logic [lif_pkg::NEURON_W-1:0] n;
    logic signed [31:0] c;
    longint t;
    longint wide;
    bit f;
    if (hot_neurons.size() > 0 && $urandom_range(1) == 1) begin
      n = hot_neurons[$urandom_range(hot_neurons.size() - 1)];
    end else begin
      n = 8'($urandom_range(255));
      hot_neurons.push_back(n);
      if (hot_neurons.size() > 4) void'(hot_neurons.pop_front());
    end
    // a neuron never written must start with first_step
    f = !touched[n] || ($urandom_range(9) == 0);
    t = longint'(thresh_now);
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: c = 32'sh7FFFFFFF;
          1: c = 32'sh80000000;
          2: c = 32'sd0;
          default: c = -32'sd1;
        endcase
      end
      1, 2, 3: c = $urandom;
      default: begin
        wide = longint'($urandom_range(32'(2 * t))) - t / 2;
        if (wide > V_MAX) wide = V_MAX;
        c = wide[31:0];
      end
    endcase
    plan(n, c, f);
  endtask

  // wait for every planned word to come back, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (reports_seen < words_planned);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [lif_pkg::THRESH_W-1:0] leak_w,
                           logic [lif_pkg::THRESH_W-1:0] thresh_w,
                           int send_pct, int stall_pct, bit hold, int count);
    write_reg(lif_pkg::REG_LEAK, leak_w);
    write_reg(lif_pkg::REG_THRESH, thresh_w);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_go = 1'b1;
    repeat (count) plan_random();
    drain();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    plan(8'd0, 32'sd0, 1'b1);
    plan(8'd255, 32'sh7FFFFFFF, 1'b1);   // top of range, spikes
    plan(8'd255, 32'sh7FFFFFFF, 1'b0);   // overflow clips high
    plan(8'd1, 32'sh80000000, 1'b1);     // bottom of range
    plan(8'd1, 32'sh80000000, 1'b0);     // underflow clips low
    plan(8'd2, 32'sd65536, 1'b1);        // exactly at threshold
    plan(8'd2, 32'sd0, 1'b0);            // subtractive reset after a spike
    plan(8'd3, 32'sd65535, 1'b1);        // just below threshold
    plan(8'd3, 32'sd65536, 1'b0);
    plan(8'hAA, 32'sh55555555, 1'b1);
    plan(8'h55, 32'shAAAAAAAA, 1'b1);
    drain();

    // half leak and minimum threshold: rounding ties, unused register indexes
    write_reg(lif_pkg::REG_LEAK, 31'd16384);
    write_reg(lif_pkg::REG_THRESH, 31'd0);
    write_reg(REG_SPARE_2, 31'($urandom));
    write_reg(REG_SPARE_3, 31'($urandom));
    plan(8'd10, 32'sd1, 1'b1);
    plan(8'd10, 32'sd0, 1'b0);           // +0.5 rounds up
    plan(8'd11, -32'sd1, 1'b1);
    plan(8'd11, 32'sd0, 1'b0);           // -0.5 rounds up to zero
    plan(8'd12, -32'sd3, 1'b1);
    plan(8'd12, 32'sd0, 1'b0);           // -1.5 rounds to -1
    plan(8'd13, 32'sd7, 1'b1);           // spike at the clamped threshold
    plan(8'd13, 32'sd0, 1'b0);
    drain();

    // random phases across register settings and idle patterns
    run_phase(31'd0, 31'h7FFFFFFF, 0, 0, 1'b0, 106);
    run_phase(31'd32767, 31'd6, 47, 0, 1'b0, 106);
    run_phase(31'(lif_pkg::LEAK_RESET), 31'(lif_pkg::THRESH_RESET), 0, 47, 1'b0, 106);
    run_phase(31'($urandom), 31'($urandom), 32, 32, 1'b0, 106);
    run_phase(31'(lif_pkg::LEAK_MAX), 31'(lif_pkg::THRESH_MIN), 0, 0, 1'b1, 106);
    run_phase(31'd1, 31'($urandom_range(1 << 20)), 47, 0, 1'b0, 106);
    run_phase(31'($urandom_range(32765)), 31'd1 << 24, 0, 47, 1'b0, 106);
    run_phase(31'd16384, 31'($urandom), 32, 32, 1'b0, 106);

    repeat (20) @(posedge clk);
    if (!failed && due_reports.size() == 0) begin
      $display("tb_lif_neuron_array_step_top OK");
    end else begin
      $display("tb_lif_neuron_array_step_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("tb_lif_neuron_array_step_top NOT OK");
    $finish;
  end

endmodule
